[design/pptg_pkg.sv]
// Package for the push-pull tone generator: constants, microcode word types
// and the control store. No dependencies.

package pptg_pkg;

    // Timer clock and limits of the tone arithmetic
    localparam logic [31:0] CLK_HZ       = 32'd64000000;
    localparam logic [23:0] MAX_TICK_HZ  = 24'd100000;
    localparam logic [23:0] TOP_MAX      = 24'd255;
    localparam logic [31:0] ENDLESS_TICKS = 32'h8000_0000;
    localparam logic [15:0] MS_PER_S     = 16'd1000;
    localparam logic [15:0] VOL_FULL     = 16'd255;
    localparam logic [3:0]  PSEL_MAX     = 4'd15;
    localparam logic [3:0]  SBITS_MAX    = 4'd8;
    localparam logic [3:0]  SBITS_MIN    = 4'd2;
    localparam logic [8:0]  PHASE_FULL   = 9'h100;

    // Reciprocal of 1000 scaled by 2^38 and rounded up: exact for any 32-bit numerator
    localparam logic [28:0] MS_RECIP       = 29'h10624DD3;
    localparam int          MS_RECIP_SHIFT = 38;

    localparam int PC_W = 5;
    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] DIV_LAST = 5'd31;

    typedef logic [PC_W-1:0] pc_t;

    // Datapath actions of one microcode step
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_RATE_INIT,
        OP_RATE_STEP,
        OP_DIV_TOP,
        OP_DIV_STEP,
        OP_TOP_INIT,
        OP_TOP_STEP,
        OP_TMO_INIT,
        OP_TMO_LOAD,
        OP_DUTY_INIT,
        OP_COMMIT,
        OP_HALT,
        OP_TICK,
        OP_EMIT
    } op_t;

    // Jump conditions; a step jumps to its target when the condition holds
    typedef enum logic [3:0] {
        CD_NEVER,
        CD_ALWAYS,
        CD_NO_INPUT,
        CD_IS_TICK,
        CD_BAD_REQ,
        CD_RATE_OK,
        CD_SBITS_LOW,
        CD_CNT_NZ,
        CD_TOP_OK,
        CD_PSEL_TOP,
        CD_ENDLESS,
        CD_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    // Step addresses
    localparam pc_t ST_FETCH     = 5'd0;
    localparam pc_t ST_KIND      = 5'd1;
    localparam pc_t ST_CHECK     = 5'd2;
    localparam pc_t ST_RATE_INIT = 5'd3;
    localparam pc_t ST_RATE_TEST = 5'd4;
    localparam pc_t ST_RATE_STEP = 5'd5;
    localparam pc_t ST_RATE_LOOP = 5'd6;
    localparam pc_t ST_DIV_TOP   = 5'd7;
    localparam pc_t ST_TOP_DIV   = 5'd8;
    localparam pc_t ST_TOP_INIT  = 5'd9;
    localparam pc_t ST_TOP_TEST  = 5'd10;
    localparam pc_t ST_TOP_STEP  = 5'd11;
    localparam pc_t ST_TOP_LOOP  = 5'd12;
    localparam pc_t ST_TMO_INIT  = 5'd13;
    localparam pc_t ST_TMO_LOAD  = 5'd14;
    localparam pc_t ST_DUTY_INIT = 5'd15;
    localparam pc_t ST_COMMIT    = 5'd16;
    localparam pc_t ST_HALT      = 5'd17;
    localparam pc_t ST_TICK      = 5'd18;
    localparam pc_t ST_EMIT      = 5'd19;
    localparam pc_t ST_RETURN    = 5'd20;

    // Control store
    function automatic ctrl_t ucode(input pc_t pc);
        ctrl_t w;
        case (pc)
            ST_FETCH:     w = '{OP_LATCH,     CD_NO_INPUT,  ST_FETCH};
            ST_KIND:      w = '{OP_NOP,       CD_IS_TICK,   ST_TICK};
            ST_CHECK:     w = '{OP_NOP,       CD_BAD_REQ,   ST_HALT};
            ST_RATE_INIT: w = '{OP_RATE_INIT, CD_NEVER,     ST_FETCH};
            ST_RATE_TEST: w = '{OP_NOP,       CD_RATE_OK,   ST_DIV_TOP};
            ST_RATE_STEP: w = '{OP_RATE_STEP, CD_SBITS_LOW, ST_HALT};
            ST_RATE_LOOP: w = '{OP_NOP,       CD_ALWAYS,    ST_RATE_TEST};
            ST_DIV_TOP:   w = '{OP_DIV_TOP,   CD_NEVER,     ST_FETCH};
            ST_TOP_DIV:   w = '{OP_DIV_STEP,  CD_CNT_NZ,    ST_TOP_DIV};
            ST_TOP_INIT:  w = '{OP_TOP_INIT,  CD_NEVER,     ST_FETCH};
            ST_TOP_TEST:  w = '{OP_NOP,       CD_TOP_OK,    ST_TMO_INIT};
            ST_TOP_STEP:  w = '{OP_TOP_STEP,  CD_PSEL_TOP,  ST_HALT};
            ST_TOP_LOOP:  w = '{OP_NOP,       CD_ALWAYS,    ST_TOP_TEST};
            ST_TMO_INIT:  w = '{OP_TMO_INIT,  CD_ENDLESS,   ST_DUTY_INIT};
            ST_TMO_LOAD:  w = '{OP_TMO_LOAD,  CD_NEVER,     ST_FETCH};
            ST_DUTY_INIT: w = '{OP_DUTY_INIT, CD_NEVER,     ST_FETCH};
            ST_COMMIT:    w = '{OP_COMMIT,    CD_ALWAYS,    ST_EMIT};
            ST_HALT:      w = '{OP_HALT,      CD_ALWAYS,    ST_EMIT};
            ST_TICK:      w = '{OP_TICK,      CD_NEVER,     ST_FETCH};
            ST_EMIT:      w = '{OP_EMIT,      CD_OUT_BUSY,  ST_EMIT};
            ST_RETURN:    w = '{OP_NOP,       CD_ALWAYS,    ST_FETCH};
            default:      w = '{OP_NOP,       CD_ALWAYS,    ST_FETCH};
        endcase
        return w;
    endfunction

endpackage

[design/push_pull_tone_generator.sv]
// Push-pull tone generator: a microcoded sequencer over a shift-subtract divider.
// A tick passes through the kind and tick steps to the emit step; a tone request runs
// the rate check, the 32-step divide for the PWM top and up to ten prescaler steps.
// One word at a time: after the result is registered the sequencer returns to fetch,
// and a held result stalls it at the emit step.
// Synchronous active-low reset clears the tone state to stopped. Uses pptg_pkg.

module push_pull_tone_generator
    import pptg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [15:0] s_frequency,
    input  logic [15:0] s_duration,
    input  logic [7:0]  s_volume,
    input  logic        s_background,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_pwm_top,
    output logic [3:0]  m_clock_select,
    output logic [7:0]  m_drive_a,
    output logic [7:0]  m_drive_d,
    output logic        m_running
);

    // Sequencer and result handshake
    pc_t   pc_reg, pc_next;
    ctrl_t ctrl;
    logic  jump;
    logic  m_valid_reg;
    logic  out_busy;

    // Tone state
    logic [7:0]  phase_acc_reg, phase_step_reg, duty_level_reg, top_value_reg;
    logic [31:0] ticks_left_reg;
    logic [3:0]  prescale_sel_reg;
    logic        active_reg;

    // Latched request word and working registers
    logic             kind_reg, bg_reg;
    logic [15:0]      freq_reg, dur_reg;
    logic [7:0]       vol_reg;
    logic [23:0]      wrk_reg;
    logic [3:0]       sbits_reg, psel_reg;
    logic [31:0]      dvd_reg, tmo_reg;
    logic [15:0]      dvs_reg, rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [7:0]       da_reg, dd_reg;

    // Output word registers
    logic [7:0] out_top_reg, out_da_reg, out_dd_reg;
    logic [3:0] out_sel_reg;
    logic       out_run_reg;

    // Datapath helpers
    logic [16:0] rem_shift, rem_diff;
    logic        rem_fits;
    logic [31:0] tmo_prod, tmo_shift;
    logic [60:0] tmo_scaled;
    logic [15:0] duty_prod, duty_sum;
    logic [7:0]  phase_acc_next;
    logic [31:0] ticks_left_next;

    assign ctrl     = ucode(pc_reg);
    assign out_busy = m_valid_reg && !m_ready;
    assign s_ready  = (pc_reg == ST_FETCH);

    // Divide one quotient bit per step
    assign rem_shift = {rem_reg, dvd_reg[31]};
    assign rem_fits  = (rem_shift >= {1'b0, dvs_reg});
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};

    // Timeout numerator wraps at 32 bits before the divide
    assign tmo_prod  = 32'(dur_reg) * 32'(freq_reg);
    assign tmo_shift = tmo_prod << sbits_reg;
    assign duty_prod = 16'(wrk_reg[7:0]) * 16'(vol_reg);

    // Divide the registered timeout numerator by 1000 through its reciprocal
    assign tmo_scaled = {29'd0, dvd_reg} * {32'd0, MS_RECIP};

    // Divide the registered duty product by 255: (x + (x >> 8) + 1) >> 8 up to 255 * 255
    assign duty_sum = dvd_reg[15:0] + {8'd0, dvd_reg[15:8]} + 16'd1;

    assign phase_acc_next  = phase_acc_reg + phase_step_reg;
    assign ticks_left_next = ticks_left_reg - 32'd1;

    // Evaluate the jump condition of the current step
    always_comb begin
        case (ctrl.cond)
            CD_NEVER:     jump = 1'b0;
            CD_ALWAYS:    jump = 1'b1;
            CD_NO_INPUT:  jump = !s_valid;
            CD_IS_TICK:   jump = kind_reg;
            CD_BAD_REQ:   jump = (freq_reg == 16'd0) || (vol_reg == 8'd0);
            CD_RATE_OK:   jump = (wrk_reg <= MAX_TICK_HZ);
            CD_SBITS_LOW: jump = (sbits_reg <= SBITS_MIN);
            CD_CNT_NZ:    jump = (cnt_reg != '0);
            CD_TOP_OK:    jump = (wrk_reg <= TOP_MAX);
            CD_PSEL_TOP:  jump = (psel_reg == PSEL_MAX);
            CD_ENDLESS:   jump = (dur_reg == 16'd0) || !bg_reg;
            CD_OUT_BUSY:  jump = out_busy;
            default:      jump = 1'b0;
        endcase
    end

    // Advance or jump
    always_comb begin
        if (jump) begin
            pc_next = ctrl.target;
        end else begin
            pc_next = pc_reg + pc_t'(1);
        end
    end

    // Control, tone state and result handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg           <= ST_FETCH;
            m_valid_reg      <= 1'b0;
            phase_acc_reg    <= '0;
            phase_step_reg   <= '0;
            duty_level_reg   <= '0;
            ticks_left_reg   <= '0;
            top_value_reg    <= '0;
            prescale_sel_reg <= '0;
            active_reg       <= 1'b0;
        end else begin
            pc_reg <= pc_next;
            // drop the valid once taken, unless a new word is loaded at this edge
            if (m_valid_reg && m_ready && (ctrl.op != OP_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            case (ctrl.op)
                OP_COMMIT: begin
                    top_value_reg    <= wrk_reg[7:0];
                    phase_step_reg   <= 8'(PHASE_FULL >> sbits_reg);
                    ticks_left_reg   <= tmo_reg;
                    duty_level_reg   <= duty_sum[15:8];
                    prescale_sel_reg <= psel_reg;
                    active_reg       <= 1'b1;
                end
                OP_HALT: begin
                    prescale_sel_reg <= '0;
                    active_reg       <= 1'b0;
                end
                OP_TICK: begin
                    if (active_reg) begin
                        phase_acc_reg  <= phase_acc_next;
                        ticks_left_reg <= ticks_left_next;
                        if (ticks_left_next == 32'd0) begin
                            prescale_sel_reg <= '0;
                            active_reg       <= 1'b0;
                        end
                    end
                end
                OP_EMIT: begin
                    if (!out_busy) begin
                        m_valid_reg <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers and result word
    always_ff @(posedge aclk) begin
        case (ctrl.op)
            OP_LATCH: begin
                if (s_valid) begin
                    kind_reg <= s_kind;
                    freq_reg <= s_frequency;
                    dur_reg  <= s_duration;
                    vol_reg  <= s_volume;
                    bg_reg   <= s_background;
                end
            end
            OP_RATE_INIT: begin
                wrk_reg   <= {freq_reg, 8'h00};
                sbits_reg <= SBITS_MAX;
            end
            OP_RATE_STEP: begin
                wrk_reg   <= wrk_reg >> 1;
                sbits_reg <= sbits_reg - 4'd1;
            end
            OP_DIV_TOP: begin
                dvd_reg <= CLK_HZ >> sbits_reg;
                dvs_reg <= freq_reg;
                rem_reg <= '0;
                cnt_reg <= DIV_LAST;
            end
            OP_DIV_STEP: begin
                dvd_reg <= {dvd_reg[30:0], rem_fits};
                rem_reg <= rem_fits ? rem_diff[15:0] : rem_shift[15:0];
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            OP_TOP_INIT: begin
                wrk_reg  <= dvd_reg[23:0];
                psel_reg <= 4'd1;
            end
            OP_TOP_STEP: begin
                wrk_reg  <= wrk_reg >> 1;
                psel_reg <= psel_reg + 4'd1;
            end
            OP_TMO_INIT: begin
                tmo_reg <= ENDLESS_TICKS;
                dvd_reg <= tmo_shift;
            end
            OP_TMO_LOAD: begin
                tmo_reg <= {9'd0, tmo_scaled[60:MS_RECIP_SHIFT]};
            end
            OP_DUTY_INIT: begin
                dvd_reg <= 32'(duty_prod);
            end
            OP_COMMIT, OP_HALT: begin
                da_reg <= '0;
                dd_reg <= '0;
            end
            OP_TICK: begin
                if (active_reg && (ticks_left_next != 32'd0)) begin
                    if (phase_acc_next[7]) begin
                        da_reg <= '0;
                        dd_reg <= duty_level_reg;
                    end else begin
                        da_reg <= duty_level_reg;
                        dd_reg <= '0;
                    end
                end else begin
                    da_reg <= '0;
                    dd_reg <= '0;
                end
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    out_top_reg <= top_value_reg;
                    out_sel_reg <= prescale_sel_reg;
                    out_da_reg  <= da_reg;
                    out_dd_reg  <= dd_reg;
                    out_run_reg <= active_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_pwm_top      = out_top_reg;
    assign m_clock_select = out_sel_reg;
    assign m_drive_a      = out_da_reg;
    assign m_drive_d      = out_dd_reg;
    assign m_running      = out_run_reg;

endmodule

[dv/testbench.sv]
// Self-checking testbench for push_pull_tone_generator: drives tone requests and
// timer ticks over valid/ready and checks every result word against its own
// tone predictor. Depends on pptg_pkg and the push_pull_tone_generator RTL.

module testbench
    import pptg_pkg::*;
();

    localparam logic KIND_TONE = 1'b0;
    localparam logic KIND_TICK = 1'b1;
    localparam int RANDOM_WORDS = 650;
    localparam int HOLD_AT = 200;
    localparam int HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES = 200;
    localparam int CYCLE_LIMIT = 800000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic        kind;
        logic [15:0] freq;
        logic [15:0] dur;
        logic [7:0]  vol;
        logic        bg;
        logic        wait_idle;
    } tone_word_t;

    typedef struct packed {
        logic [7:0] top;
        logic [3:0] sel;
        logic [7:0] drv_a;
        logic [7:0] drv_d;
        logic       on;
    } pwm_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = 1'b0;
    logic [15:0] s_frequency = '0;
    logic [15:0] s_duration = '0;
    logic [7:0]  s_volume = '0;
    logic        s_background = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_pwm_top;
    logic [3:0]  m_clock_select;
    logic [7:0]  m_drive_a;
    logic [7:0]  m_drive_d;
    logic        m_running;

    push_pull_tone_generator u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_frequency    (s_frequency),
        .s_duration     (s_duration),
        .s_volume       (s_volume),
        .s_background   (s_background),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pwm_top      (m_pwm_top),
        .m_clock_select (m_clock_select),
        .m_drive_a      (m_drive_a),
        .m_drive_d      (m_drive_d),
        .m_running      (m_running)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Tone state as seen by the predictor
    logic [7:0]  tone_acc = '0;
    logic [7:0]  tone_step = '0;
    logic [7:0]  tone_duty = '0;
    logic [31:0] tone_left = '0;
    logic [7:0]  tone_top = '0;
    logic [3:0]  tone_sel = '0;
    logic        tone_on = 1'b0;

    tone_word_t tone_words[$];
    pwm_word_t  pending_pwm[$];
    tone_word_t cur_word;

    int words_total = 0;
    int words_accepted = 0;
    int words_checked = 0;
    int mismatches = 0;
    int cycles = 0;
    int n_requests = 0;
    int n_started = 0;
    int n_refused = 0;
    int n_ticks = 0;
    int n_expired = 0;

    // Advance the tone state by one word and return the result it causes
    function automatic pwm_word_t step_tone(input tone_word_t w);
        pwm_word_t   r;
        logic [7:0]  da;
        logic [7:0]  dd;
        logic [31:0] rate;
        logic [31:0] top;
        logic [31:0] tmo;
        logic [31:0] prod;
        logic [3:0]  sbits;
        int          psel;
        bit          bad;
        da = '0;
        dd = '0;
        if (w.kind == KIND_TONE) begin
            n_requests++;
            bad = (w.freq == 0) || (w.vol == 0);
            sbits = SBITS_MAX;
            rate = {8'd0, w.freq, 8'd0};
            psel = 1;
            top = '0;
            // drop sample bits until the tick rate fits
            while (!bad && rate > {8'd0, MAX_TICK_HZ}) begin
                sbits--;
                if (sbits < SBITS_MIN) bad = 1;
                rate >>= 1;
            end
            // raise the prescaler until the top fits in eight bits
            if (!bad) begin
                top = (CLK_HZ >> sbits) / {16'd0, w.freq};
                while (!bad && top > {8'd0, TOP_MAX}) begin
                    psel++;
                    if (psel > int'(PSEL_MAX)) bad = 1;
                    top >>= 1;
                end
            end
            if (bad) begin
                n_refused++;
                tone_on = 1'b0;
                tone_sel = '0;
            end else begin
                n_started++;
                if (w.dur != 0 && w.bg) begin
                    prod = {16'd0, w.dur} * {16'd0, w.freq};
                    tmo = (prod << sbits) / {16'd0, MS_PER_S};
                end else begin
                    tmo = ENDLESS_TICKS;
                end
                tone_top = top[7:0];
                tone_step = 8'(PHASE_FULL >> sbits);
                tone_left = tmo;
                tone_duty = 8'((top * {24'd0, w.vol}) / {16'd0, VOL_FULL});
                tone_sel = 4'(psel);
                tone_on = 1'b1;
            end
        end else begin
            n_ticks++;
            if (tone_on) begin
                tone_acc = tone_acc + tone_step;
                if (tone_acc[7]) dd = tone_duty;
                else da = tone_duty;
                tone_left = tone_left - 1;
                // the timeout ran out: stop and silence both outputs
                if (tone_left == 0) begin
                    n_expired++;
                    tone_on = 1'b0;
                    tone_sel = '0;
                    da = '0;
                    dd = '0;
                end
            end
        end
        r.top = tone_top;
        r.sel = tone_sel;
        r.drv_a = da;
        r.drv_d = dd;
        r.on = tone_on;
        return r;
    endfunction

    function automatic tone_word_t make_word(input logic kind, input int f, input int d,
                                             input int v, input int bg);
        tone_word_t w;
        w.kind = kind;
        w.freq = 16'(f);
        w.dur = 16'(d);
        w.vol = 8'(v);
        w.bg = 1'(bg);
        w.wait_idle = 1'b0;
        return w;
    endfunction

    function automatic tone_word_t rand_tick();
        return make_word(KIND_TICK, $urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 255), $urandom_range(0, 1));
    endfunction

    // A request the block will accept, across the prescaler range
    function automatic tone_word_t rand_good_tone();
        int f;
        int d;
        case ($urandom_range(0, 2))
            0: f = $urandom_range(1, 300);
            1: f = $urandom_range(300, 3000);
            default: f = $urandom_range(3000, 25000);
        endcase
        d = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 65535);
        return make_word(KIND_TONE, f, d, $urandom_range(1, 255), $urandom_range(0, 1));
    endfunction

    // Sender: bursts of words with random gaps, holding for drain points
    int burst_left = 8;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // queue the result of the word taken at this edge
            if (s_valid && s_ready) begin
                pending_pwm.push_back(step_tone(cur_word));
                words_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (tone_words.size() != 0 &&
                             !(tone_words[0].wait_idle && pending_pwm.size() != 0)) begin
                    cur_word = tone_words.pop_front();
                    s_valid <= 1'b1;
                    s_kind <= cur_word.kind;
                    s_frequency <= cur_word.freq;
                    s_duration <= cur_word.dur;
                    s_volume <= cur_word.vol;
                    s_background <= cur_word.bg;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60)
                                                              : $urandom_range(0, 4);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern switched each time the 6-bit phase counter wraps, plus one long hold
    logic [5:0] stall_phase = '0;
    logic [1:0] stall_mode = '0;
    int  hold_left = 0;
    bit  hold_done = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && words_accepted >= HOLD_AT) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            stall_phase <= stall_phase + 6'd1;
            if (stall_phase == 0) stall_mode <= 2'($urandom_range(0, 3));
            case (stall_mode)
                2'd0: m_ready <= 1'b1;
                2'd1: m_ready <= 1'($urandom_range(0, 1));
                2'd2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ~stall_phase[2];
            endcase
        end
    end

    // Check each result word against the oldest prediction
    pwm_word_t got;
    pwm_word_t want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got = '{m_pwm_top, m_clock_select, m_drive_a, m_drive_d, m_running};
            if (pending_pwm.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result word with none expected: top=%0d sel=%0d a=%0d d=%0d run=%0b",
                             $time, got.top, got.sel, got.drv_a, got.drv_d, got.on);
            end else begin
                want = pending_pwm.pop_front();
                words_checked++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: word %0d expected top=%0d sel=%0d a=%0d d=%0d run=%0b",
                                 $time, words_checked, want.top, want.sel, want.drv_a,
                                 want.drv_d, want.on);
                        $display("%0t: word %0d actual   top=%0d sel=%0d a=%0d d=%0d run=%0b",
                                 $time, words_checked, got.top, got.sel, got.drv_a,
                                 got.drv_d, got.on);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_pwm.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // Stimulus and end of run
    int kind_sel;
    int n_ticks_seq;
    tone_word_t req;

    initial begin
        // Directed: idle tick, each refusal, edge frequencies, timeout corners
        tone_words.push_back(rand_tick());
        tone_words.push_back(make_word(KIND_TONE, 0, 100, 255, 1));
        tone_words.push_back(make_word(KIND_TONE, 440, 100, 0, 1));
        tone_words.push_back(make_word(KIND_TONE, 65535, 65535, 255, 1));
        tone_words.push_back(make_word(KIND_TONE, 25000, 0, 255, 1));
        tone_words.push_back(rand_tick());
        tone_words.push_back(rand_tick());
        tone_words.push_back(make_word(KIND_TONE, 25001, 10, 255, 1));
        tone_words.push_back(rand_tick());
        // timeout rounds to zero: the count wraps and the tone keeps going
        req = make_word(KIND_TONE, 1, 1, 255, 1);
        req.wait_idle = 1'b1;
        tone_words.push_back(req);
        tone_words.push_back(rand_tick());
        tone_words.push_back(rand_tick());
        // one-tick timeout, then an idle tick after the stop
        tone_words.push_back(make_word(KIND_TONE, 4, 1, 128, 1));
        tone_words.push_back(rand_tick());
        tone_words.push_back(rand_tick());
        // foreground request with a duration runs endless
        tone_words.push_back(make_word(KIND_TONE, 1000, 65535, 255, 0));
        tone_words.push_back(rand_tick());
        tone_words.push_back(rand_tick());
        tone_words.push_back(rand_tick());
        // timeout product wraps past 32 bits
        tone_words.push_back(make_word(KIND_TONE, 390, 65535, 1, 1));
        tone_words.push_back(rand_tick());
        tone_words.push_back(rand_tick());
        tone_words.push_back(make_word(KIND_TONE, 1, 0, 1, 0));
        tone_words.push_back(rand_tick());

        // Random: mostly request-then-ticks sequences, some noise
        while (tone_words.size() < 24 + RANDOM_WORDS) begin
            kind_sel = $urandom_range(0, 99);
            n_ticks_seq = 0;
            if (kind_sel < 55) begin
                req = rand_good_tone();
                n_ticks_seq = $urandom_range(1, 24);
            end else if (kind_sel < 70) begin
                // short timeout that may expire within the following ticks
                req = make_word(KIND_TONE, $urandom_range(1, 40), $urandom_range(1, 2),
                                $urandom_range(1, 255), 1);
                n_ticks_seq = $urandom_range(1, 25);
            end else if (kind_sel < 80) begin
                req = make_word(KIND_TONE, $urandom_range(0, 65535), $urandom_range(0, 65535),
                                $urandom_range(0, 255), $urandom_range(0, 1));
                n_ticks_seq = $urandom_range(0, 5);
            end else if (kind_sel < 88) begin
                case ($urandom_range(0, 2))
                    0: req = make_word(KIND_TONE, 0, $urandom_range(0, 65535),
                                       $urandom_range(0, 255), $urandom_range(0, 1));
                    1: req = make_word(KIND_TONE, $urandom_range(0, 65535),
                                       $urandom_range(0, 65535), 0, $urandom_range(0, 1));
                    default: req = make_word(KIND_TONE, $urandom_range(25001, 65535),
                                             $urandom_range(0, 65535),
                                             $urandom_range(1, 255), $urandom_range(0, 1));
                endcase
                n_ticks_seq = $urandom_range(0, 3);
            end else begin
                req = rand_tick();
            end
            if ($urandom_range(0, 11) == 0) req.wait_idle = 1'b1;
            tone_words.push_back(req);
            repeat (n_ticks_seq) tone_words.push_back(rand_tick());
        end
        words_total = tone_words.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (words_accepted < words_total || pending_pwm.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_pwm.size() != 0) mismatches++;

        $display("covered %0d words: %0d tone requests (%0d started, %0d refused), %0d ticks",
                 words_total, n_requests, n_started, n_refused, n_ticks);
        $display("%0d timeouts expired, %0d results checked, %0d mismatches",
                 n_expired, words_checked, mismatches);
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
